// ----- hdl/oaht_pkg.sv -----
// ----------------------------------------------------------------------------
// Open-addressing hash table: shared package
// Types and codes shared by the hash table modules.
// ----------------------------------------------------------------------------
package oaht_pkg;

   // Fixed field widths.
   localparam int KEY_W      = 31;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 10;
   localparam int PROBES_W   = 11;
   localparam int MODE_W     = 2;
   localparam int SIZE_W     = 11;
   localparam int ENTRY_W    = KEY_W + 1;

   // Divider step counter: one key bit per cycle.
   localparam int DIV_CNT_W  = $clog2(KEY_W + 1);

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // Probe modes.
   localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUADRATIC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DOUBLE    = 2'd2;

   // Register indexes.
   localparam logic REG_PROBE_MODE = 1'b0;
   localparam logic REG_TABLE_SIZE = 1'b1;

   // Register reset values.
   localparam logic [MODE_W-1:0] PROBE_MODE_RST = 2'd0;
   localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1021;

   // Base of the second hash.
   localparam logic [2:0] DH_BASE = 3'd5;

   // One slot of the table.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } entry_type;

   // Result of the modulo unit.
   typedef struct packed {
      logic       done;
      logic [2:0] rem5;
   } mod_status_type;

endpackage

// ----- hdl/oaht_mem.sv -----
// ----------------------------------------------------------------------------
// Open-addressing hash table: slot memory
// Single-port-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module oaht_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  oaht_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output oaht_pkg::entry_type rd_data
);

   oaht_pkg::entry_type slot_mem_ff [DEPTH];
   oaht_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/oaht_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Open-addressing hash table: modulo unit
// Bit-serial restoring reduction of the key by the table size and by five.
// ----------------------------------------------------------------------------
module oaht_mod_unit #(
   parameter int SW = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [oaht_pkg::KEY_W-1:0]    key,
   input  logic [SW-1:0]                 divisor,
   output logic [SW-1:0]                 rem,
   output oaht_pkg::mod_status_type      status
);

   logic [oaht_pkg::KEY_W-1:0]     shift_ff, shift_in;
   logic [SW-1:0]                  rem_ff, rem_in;
   logic [2:0]                     rem5_ff, rem5_in;
   logic [oaht_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [SW:0]                    trial;
   logic [3:0]                     trial5;

   // One key bit per cycle, most significant first.
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      rem5_in  = rem5_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[oaht_pkg::KEY_W-1]};
      trial5   = {rem5_ff, shift_ff[oaht_pkg::KEY_W-1]};
      if (start) begin
         shift_in = key;
         rem_in   = '0;
         rem5_in  = '0;
         cnt_in   = oaht_pkg::DIV_CNT_W'(oaht_pkg::KEY_W);
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[oaht_pkg::KEY_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = SW'(trial - {1'b0, divisor});
         end else begin
            rem_in = SW'(trial);
         end
         if (trial5 >= 4'(oaht_pkg::DH_BASE)) begin
            rem5_in = 3'(trial5 - 4'(oaht_pkg::DH_BASE));
         end else begin
            rem5_in = 3'(trial5);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == oaht_pkg::DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      rem5_ff  <= rem5_in;
      cnt_ff   <= cnt_in;
   end

   assign rem         = rem_ff;
   assign status.done = done_ff;
   assign status.rem5 = rem5_ff;

endmodule

// ----- hdl/open_addressing_hash_table_top.sv -----
// ----------------------------------------------------------------------------
// Open-addressing hash table
// Insert and search of 31-bit keys with linear, quadratic or double hashing.
// ----------------------------------------------------------------------------
// Channel   Ports                                        Direction
// command   start, busy, req_operation, req_key          in (busy out)
// result    rsp_valid, rsp_status, rsp_position,         out
//           rsp_probes
// config    csr_write, csr_index, csr_data               in
//
// An item first passes the bit-serial modulo unit for the home slot, then
// takes one memory read and one check per probe. After reset the slots are
// cleared, one per cycle, while busy is high. The result strobe lasts one
// cycle; the receiver cannot stall it. Busy is high from acceptance until
// the result is shown.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [oaht_pkg::KEY_W-1:0]        req_key,
   output logic                              rsp_valid,
   output logic [oaht_pkg::STATUS_W-1:0]     rsp_status,
   output logic [oaht_pkg::POSITION_W-1:0]   rsp_position,
   output logic [oaht_pkg::PROBES_W-1:0]     rsp_probes,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [oaht_pkg::SIZE_W-1:0]       csr_data
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam int W1 = AW + 1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [oaht_pkg::MODE_W-1:0]         mode_ff, mode_in;
   logic [oaht_pkg::SIZE_W-1:0]         size_ff, size_in;
   logic                                op_ff, op_in;
   logic [oaht_pkg::KEY_W-1:0]          key_ff, key_in;
   logic [SW-1:0]                       eff_ff, eff_in;
   logic [AW-1:0]                       pos_ff, pos_in;
   logic [AW-1:0]                       inc_ff, inc_in;
   logic [SW-1:0]                       k_ff, k_in;
   logic [AW-1:0]                       clr_ff, clr_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [oaht_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [AW-1:0]                       rsp_pos_ff, rsp_pos_in;
   logic [SW-1:0]                       rsp_k_ff, rsp_k_in;

   logic [SW-1:0]                       eff_size;
   logic                                accept;
   logic                                mod_start;
   logic [SW-1:0]                       mod_rem;
   oaht_pkg::mod_status_type            mod_stat;
   logic                                wr_en;
   logic [AW-1:0]                       wr_addr;
   oaht_pkg::entry_type                 wr_data;
   logic                                rd_en;
   oaht_pkg::entry_type                 rd_data;
   logic [W1-1:0]                       step0;
   logic [W1-1:0]                       step1;
   logic [W1-1:0]                       step2;
   logic [W1-1:0]                       size_w;
   logic [W1-1:0]                       pos_sum;
   logic [W1-1:0]                       quad_sum;
   logic [SW-1:0]                       k_next;
   logic [31:0]                         pos_wide;
   logic [31:0]                         k_wide;

   // Effective size: the size register saturated to 2..MAX_SLOTS.
   always_comb begin
      if (size_ff < oaht_pkg::SIZE_W'(2)) begin
         eff_size = SW'(2);
      end else if (32'(size_ff) > 32'(MAX_SLOTS)) begin
         eff_size = SW'(MAX_SLOTS);
      end else begin
         eff_size = SW'(size_ff);
      end
   end

   assign accept    = start && (state_ff == S_IDLE);
   assign mod_start = accept;
   assign size_w    = W1'(eff_ff);

   // Second-hash step reduced by the table size; it never exceeds five.
   always_comb begin
      step0 = W1'(oaht_pkg::DH_BASE - mod_stat.rem5);
      step1 = (step0 >= size_w) ? W1'(step0 - size_w) : step0;
      step2 = (step1 >= size_w) ? W1'(step1 - size_w) : step1;
   end

   // Next probe position and next quadratic increment.
   always_comb begin
      pos_sum  = W1'(pos_ff) + W1'(inc_ff);
      quad_sum = W1'(inc_ff) + W1'(2);
      k_next   = k_ff + 1'b1;
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      size_in       = size_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      eff_in        = eff_ff;
      pos_in        = pos_ff;
      inc_in        = inc_ff;
      k_in          = k_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_k_in      = rsp_k_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = '{valid: 1'b1, key: key_ff};
      rd_en         = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            oaht_pkg::REG_PROBE_MODE: mode_in = csr_data[oaht_pkg::MODE_W-1:0];
            oaht_pkg::REG_TABLE_SIZE: size_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '{valid: 1'b0, key: '0};
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(MAX_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               key_in   = req_key;
               eff_in   = eff_size;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (mod_stat.done) begin
               pos_in = AW'(mod_rem);
               k_in   = '0;
               if (mode_ff == oaht_pkg::MODE_DOUBLE) begin
                  inc_in = AW'(step2);
               end else begin
                  inc_in = AW'(1);
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (op_ff == oaht_pkg::OP_INSERT && !rd_data.valid) begin
               wr_en         = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = oaht_pkg::ST_INSERTED;
               rsp_pos_in    = pos_ff;
               rsp_k_in      = k_ff;
               state_in      = S_IDLE;
            end else if (op_ff == oaht_pkg::OP_SEARCH && !rd_data.valid) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = oaht_pkg::ST_NOT_FOUND;
               rsp_pos_in    = '0;
               rsp_k_in      = k_ff;
               state_in      = S_IDLE;
            end else if (op_ff == oaht_pkg::OP_SEARCH && rd_data.key == key_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = oaht_pkg::ST_FOUND;
               rsp_pos_in    = pos_ff;
               rsp_k_in      = k_ff;
               state_in      = S_IDLE;
            end else if (k_next == eff_ff) begin
               // Every slot of the probe sequence was visited.
               rsp_valid_in  = 1'b1;
               rsp_status_in = (op_ff == oaht_pkg::OP_INSERT) ?
                               oaht_pkg::ST_FULL : oaht_pkg::ST_NOT_FOUND;
               rsp_pos_in    = '0;
               rsp_k_in      = eff_ff;
               state_in      = S_IDLE;
            end else begin
               k_in   = k_next;
               pos_in = (pos_sum >= size_w) ? AW'(pos_sum - size_w) : AW'(pos_sum);
               if (mode_ff == oaht_pkg::MODE_QUADRATIC) begin
                  // Offsets k*k differ by 2k+1, kept reduced by the size.
                  inc_in = (quad_sum >= size_w) ? AW'(quad_sum - size_w) : AW'(quad_sum);
               end
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mode_ff      <= oaht_pkg::PROBE_MODE_RST;
         size_ff      <= oaht_pkg::TABLE_SIZE_RST;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         size_ff      <= size_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      eff_ff        <= eff_in;
      pos_ff        <= pos_in;
      inc_ff        <= inc_in;
      k_ff          <= k_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_k_ff      <= rsp_k_in;
   end

   oaht_mod_unit #(
      .SW (SW)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .key     (req_key),
      .divisor (eff_size),
      .rem     (mod_rem),
      .status  (mod_stat)
   );

   oaht_mem #(
      .DEPTH (MAX_SLOTS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // Outputs, masked to the field widths.
   assign pos_wide     = 32'(rsp_pos_ff);
   assign k_wide       = 32'(rsp_k_ff);
   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = pos_wide[oaht_pkg::POSITION_W-1:0];
   assign rsp_probes   = k_wide[oaht_pkg::PROBES_W-1:0];

endmodule
